FILE: hdl/dach_pkg.sv
`default_nettype none
package dach_pkg;

	localparam int FRAC_BITS_DEF       = 24;
	localparam int EXP_TABLE_DEPTH_DEF = 256;
	localparam int WORD_W              = 32;
	localparam int CFG_IDX_W           = 3;
	localparam int CHAN_STAGES         = 16;

	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;
	localparam logic [63:0] LIM62     = 64'h4000_0000_0000_0000;

	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

	// reset values in thousandths
	localparam int MILLI_WELL_DEPTH       = 100;
	localparam int MILLI_WELL_WIDTH       = 28;
	localparam int MILLI_COUPLING_STRENGTH = 15;
	localparam int MILLI_COUPLING_WIDTH   = 60;
	localparam int MILLI_ASYMPTOTE_OFFSET = 50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WELL_DEPTH        = 3'd0,
		REG_WELL_WIDTH        = 3'd1,
		REG_COUPLING_STRENGTH = 3'd2,
		REG_COUPLING_WIDTH    = 3'd3,
		REG_ASYMPTOTE_OFFSET  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [32:0] energy;
		logic signed [63:0] slope;
		logic signed [63:0] curv;
		logic               ovf;
	} chan_res_t;

	typedef struct packed {
		logic [31:0] value;
		logic        ovf;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		r.ovf = 1'b0;
		r.value = v[31:0];
		if (v > S32_MAX) begin
			r.value = S32_MAX[31:0];
			r.ovf = 1'b1;
		end else if (v < S32_MIN) begin
			r.value = S32_MIN[31:0];
			r.ovf = 1'b1;
		end
		return r;
	endfunction

	// 2^(-i/2^lg) in Q30 from a Taylor series of exp(-y) carried in Q60
	function automatic logic [30:0] exp_tab_entry(input int unsigned i, input int unsigned lg);
		logic [63:0]  sq;
		logic [63:0]  sr;
		logic [63:0]  y;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [127:0] pr;
		sq = LN2_Q60 >> lg;
		sr = LN2_Q60 & ((64'd1 << lg) - 64'd1);
		y = sq * 64'(i) + ((sr * 64'(i)) >> lg);
		term = 64'd1 << 60;
		sum = term;
		for (int n = 1; n <= 30; n++) begin
			pr = 128'(term) * 128'(y) + (128'd1 << 59);
			term = 64'(pr >> 60) / 64'(n);
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return 31'((sum + (64'd1 << 29)) >> 30);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/dach_if.sv
`default_nettype none
interface dach_in_if import dach_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] coordinate;

	modport source(output valid, coordinate, input ready);
	modport sink(input valid, coordinate, output ready);
endinterface

interface dach_out_if import dach_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] diag_energy;
	logic signed [WORD_W-1:0] coupling_energy;
	logic signed [WORD_W-1:0] diag_slope;
	logic signed [WORD_W-1:0] coupling_slope;
	logic signed [WORD_W-1:0] diag_curvature;
	logic signed [WORD_W-1:0] coupling_curvature;
	logic                     overflow;

	modport source(output valid, diag_energy, coupling_energy, diag_slope, coupling_slope,
		diag_curvature, coupling_curvature, overflow, input ready);
	modport sink(input valid, diag_energy, coupling_energy, diag_slope, coupling_slope,
		diag_curvature, coupling_curvature, overflow, output ready);
endinterface
`default_nettype wire

FILE: hdl/dach_chan.sv
`default_nettype none
// One Gaussian term amp*exp(-w*x^2) with its first and second derivative terms.
module dach_chan import dach_pkg::*; #(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic [CHAN_STAGES-1:0]  en,
	input  wire logic [30:0]             width,
	input  wire logic signed [31:0]      amp,
	input  wire logic [62-FRAC_BITS:0]   x2_mag,
	input  wire logic [31:0]             x_mag,
	input  wire logic                    x_neg,
	output chan_res_t                    res
);

	localparam int FB   = FRAC_BITS;
	localparam int X2W  = 63 - FB;
	localparam int XL   = X2W / 2;
	localparam int XH   = X2W - XL;
	localparam int PLW  = 31 + XL;
	localparam int PHW  = 31 + XH;
	localparam int TSW  = 32 + X2W;
	localparam int TW   = TSW - FB;
	localparam int TLW  = FB + 5;
	localparam int TLP  = TLW + 31;
	localparam int IDXB = $clog2(EXP_TABLE_DEPTH);
	localparam int FLW  = 32 - IDXB;
	localparam int FPW  = FLW + 30;
	localparam int DW   = FLW - 2;
	localparam int DDW  = 2 * DW;
	localparam int GW   = FB + 1;
	localparam int WXW  = 64 - FB;
	localparam int MPW  = 32 + GW;
	localparam int NPW  = WXW + 32;
	localparam int NHW  = WXW + 16;
	localparam int NW   = NPW - FB;
	localparam int Q1W  = 64 - FB;
	localparam int NL   = NW / 2;
	localparam int NH   = NW - NL;
	localparam int RLW  = WXW + NL;
	localparam int RHW  = WXW + NH;
	localparam int RSW  = WXW + NW + 1;
	localparam int RQW  = RSW - FB;
	localparam int CW   = (RQW > 63) ? RQW : 63;

	logic [30:0] exp_rom [EXP_TABLE_DEPTH];
	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
		assign exp_rom[gi] = exp_tab_entry(gi, IDXB);
	end

	logic [PLW-1:0]   pl_s4;
	logic [PHW-1:0]   ph_s4;
	logic [63:0]      wxp_s4;
	logic             sx_s4;
	logic [TSW-1:0]   tsum_s5;
	logic [WXW-1:0]   wx_s5, wx_s6, wx_s7, wx_s8, wx_s9, wx_s10, wx_s11, wx_s12;
	logic [WXW-1:0]   wx_s13, wx_s14, wx_s15;
	logic             sx_s5, sx_s6, sx_s7, sx_s8, sx_s9, sx_s10, sx_s11, sx_s12, sx_s13, sx_s14;
	logic             tz_s6, tz_s7, tz_s8, tz_s9, tz_s10;
	logic [TLP-1:0]   tlp_s6;
	logic [5:0]       k_s7, k_s8, k_s9, k_s10;
	logic [IDXB-1:0]  idx_s7;
	logic [FPW-1:0]   fp_s7;
	logic [DW-1:0]    d_s8;
	logic [DDW-1:0]   ddp_s8;
	logic [30:0]      tab_s8, tab_s9;
	logic [30:0]      p_s9;
	logic [61:0]      vp_s10;
	logic [GW-1:0]    g_s11;
	logic [MPW-1:0]   mp_s12;
	logic             sm_s12, sm_s13, sm_s14, sm_s15, sm_s16, sm_s17, sm_s18;
	logic [31:0]      m_s13, m_s14, m_s15, m_s16, m_s17, m_s18;
	logic [NHW-1:0]   npl_s14;
	logic [NHW-1:0]   nph_s14;
	logic [63:0]      q1p_s14;
	logic [NW-1:0]    n_s15, n_s16, n_s17, n_s18;
	logic [Q1W-1:0]   q1_s15, q1_s16, q1_s17, q1_s18;
	logic             sn_s15, sn_s16, sn_s17, sn_s18;
	logic [RLW-1:0]   rl_s16;
	logic [RHW-1:0]   rh_s16;
	logic [RSW-1:0]   rsum_s17;
	logic [62:0]      rmag_s18;
	logic             rov_s18;
	logic signed [32:0] energy_s19;
	logic signed [63:0] slope_s19;
	logic signed [63:0] curv_s19;
	logic               ovf_s19;

	logic [TW-1:0]    t_c;
	logic [37:0]      u_c;
	logic [DW-1:0]    d_c;
	logic [30:0]      v_c;
	logic [6:0]       s_c;
	logic [63:0]      grnd_c;
	logic [63:0]      gsh_c;
	logic [31:0]      amag_c;
	logic [RQW-1:0]   rq_c;
	logic [CW-1:0]    rqw_c;
	logic signed [63:0] diff_c;

	always_comb begin
		t_c    = tsum_s5[TSW-1:FB];
		u_c    = tlp_s6[FB-2 +: 38];
		d_c    = fp_s7[FPW-1:32];
		v_c    = vp_s10[60:30];
		s_c    = 7'(30 - FB) + {1'b0, k_s10};
		grnd_c = 64'(v_c) + (64'd1 << (s_c - 7'd1));
		gsh_c  = grnd_c >> s_c;
		amag_c = amp[31] ? 32'(-amp) : 32'(amp);
		rq_c   = rsum_s17[RSW-1:FB];
		rqw_c  = CW'(rq_c);
		diff_c = $signed(64'(q1_s18)) - $signed({1'b0, rmag_s18});
	end

	// square scaled by the width, split in two partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pl_s4  <= PLW'(width) * PLW'(x2_mag[XL-1:0]);
			ph_s4  <= PHW'(width) * PHW'(x2_mag[X2W-1:XL]);
			wxp_s4 <= 64'({width, 1'b0}) * 64'(x_mag);
			sx_s4  <= x_neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			tsum_s5 <= (TSW'(ph_s4) << XL) + TSW'(pl_s4) + (TSW'(1) << (FB - 1));
			wx_s5   <= WXW'((wxp_s4 + (64'd1 << (FB - 1))) >> FB);
			sx_s5   <= sx_s4;
		end
	end

	// exp(-t) = 2^-(t*log2e): integer part k, fraction split into table index and rest
	always_ff @(posedge clk) begin
		if (en[2]) begin
			tz_s6  <= t_c >= (TW'(32) << FB);
			tlp_s6 <= TLP'(t_c[TLW-1:0]) * TLP'(LOG2E_Q30);
			wx_s6  <= wx_s5;
			sx_s6  <= sx_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			k_s7   <= u_c[37:32];
			idx_s7 <= u_c[31 -: IDXB];
			fp_s7  <= FPW'(u_c[FLW-1:0]) * FPW'(LN2_Q30);
			tz_s7  <= tz_s6;
			wx_s7  <= wx_s6;
			sx_s7  <= sx_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d_s8   <= d_c;
			ddp_s8 <= DDW'(d_c) * DDW'(d_c);
			tab_s8 <= exp_rom[idx_s7];
			k_s8   <= k_s7;
			tz_s8  <= tz_s7;
			wx_s8  <= wx_s7;
			sx_s8  <= sx_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			p_s9   <= 31'(32'd1 << 30) - 31'(d_s8) + 31'(ddp_s8 >> 31);
			tab_s9 <= tab_s8;
			k_s9   <= k_s8;
			tz_s9  <= tz_s8;
			wx_s9  <= wx_s8;
			sx_s9  <= sx_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			vp_s10  <= 62'(tab_s9) * 62'(p_s9);
			k_s10   <= k_s9;
			tz_s10  <= tz_s9;
			wx_s10  <= wx_s9;
			sx_s10  <= sx_s9;
		end
	end

	// scale back by 2^k with rounding
	always_ff @(posedge clk) begin
		if (en[7]) begin
			g_s11  <= tz_s10 ? '0 : gsh_c[GW-1:0];
			wx_s11 <= wx_s10;
			sx_s11 <= sx_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			mp_s12 <= MPW'(amag_c) * MPW'(g_s11);
			sm_s12 <= amp[31];
			wx_s12 <= wx_s11;
			sx_s12 <= sx_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			m_s13  <= 32'((mp_s12 + (MPW'(1) << (FB - 1))) >> FB);
			sm_s13 <= sm_s12;
			wx_s13 <= wx_s12;
			sx_s13 <= sx_s12;
		end
	end

	// scaled coordinate times the energy term, split over the energy's halves
	always_ff @(posedge clk) begin
		if (en[10]) begin
			npl_s14 <= NHW'(wx_s13) * NHW'(m_s13[15:0]);
			nph_s14 <= NHW'(wx_s13) * NHW'(m_s13[31:16]);
			q1p_s14 <= 64'({width, 1'b0}) * 64'(m_s13);
			m_s14   <= m_s13;
			sm_s14  <= sm_s13;
			wx_s14  <= wx_s13;
			sx_s14  <= sx_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			n_s15  <= NW'(((NPW'(nph_s14) << 16) + NPW'(npl_s14)
				+ (NPW'(1) << (FB - 1))) >> FB);
			q1_s15 <= Q1W'((q1p_s14 + (64'd1 << (FB - 1))) >> FB);
			sn_s15 <= sx_s14 ^ sm_s14;
			m_s15  <= m_s14;
			sm_s15 <= sm_s14;
			wx_s15 <= wx_s14;
		end
	end

	// slope term times the scaled coordinate, split over the slope's halves
	always_ff @(posedge clk) begin
		if (en[12]) begin
			rl_s16 <= RLW'(wx_s15) * RLW'(n_s15[NL-1:0]);
			rh_s16 <= RHW'(wx_s15) * RHW'(n_s15[NW-1:NL]);
			n_s16  <= n_s15;
			sn_s16 <= sn_s15;
			q1_s16 <= q1_s15;
			m_s16  <= m_s15;
			sm_s16 <= sm_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			rsum_s17 <= (RSW'(rh_s16) << NL) + RSW'(rl_s16) + (RSW'(1) << (FB - 1));
			n_s17    <= n_s16;
			sn_s17   <= sn_s16;
			q1_s17   <= q1_s16;
			m_s17    <= m_s16;
			sm_s17   <= sm_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en[14]) begin
			if (rqw_c > CW'(LIM62)) begin
				rmag_s18 <= 63'(LIM62);
				rov_s18  <= 1'b1;
			end else begin
				rmag_s18 <= 63'(rqw_c);
				rov_s18  <= 1'b0;
			end
			n_s18  <= n_s17;
			sn_s18 <= sn_s17;
			q1_s18 <= q1_s17;
			m_s18  <= m_s17;
			sm_s18 <= sm_s17;
		end
	end

	// the curvature product carries the amplitude's sign
	always_ff @(posedge clk) begin
		if (en[15]) begin
			energy_s19 <= sm_s18 ? -$signed({1'b0, m_s18}) : $signed({1'b0, m_s18});
			slope_s19  <= sn_s18 ? -$signed(64'(n_s18)) : $signed(64'(n_s18));
			curv_s19   <= sm_s18 ? -diff_c : diff_c;
			ovf_s19    <= rov_s18;
		end
	end

	always_comb begin
		res.energy = energy_s19;
		res.slope  = slope_s19;
		res.curv   = curv_s19;
		res.ovf    = ovf_s19;
	end

endmodule
`default_nettype wire

FILE: hdl/dual_avoided_crossing_hamiltonian_unit.sv
// Dual avoided crossing Hamiltonian, two diabatic states, signed fixed point.
// Input channel coord carries one coordinate x per transaction; output channel
// result carries H11 = E - A*exp(-B*x^2), H01 = C*exp(-D*x^2), their first and
// second derivatives and an overflow flag (set when a value saturated).
// Constants A, B, C, D, E are written through cfg_we / cfg_index / cfg_data. The
// user must write them while no transaction is in flight; the block does not
// enforce this. Throughput: one transaction per cycle while result.ready is high,
// set by the 20-stage pipeline with a valid bit per stage.
// Each of the two lanes has its own constant exp ROM, read once per item.
// When result.ready is low the pipeline holds only as far as it is full: empty
// stages still fill, and coord.ready drops only when every stage holds an item.
// Reset clears all valid bits and loads the default constants; nothing else
// needs clearing.
`default_nettype none
module dual_avoided_crossing_hamiltonian_unit import dach_pkg::*; #(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	dach_in_if.sink                   coord,
	dach_out_if.source                result
);

	localparam int NS  = CHAN_STAGES + 4;
	localparam int X2W = 63 - FRAC_BITS;

	localparam logic [31:0] RST_WELL_DEPTH =
		32'(((64'(MILLI_WELL_DEPTH) << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [30:0] RST_WELL_WIDTH =
		31'(((64'(MILLI_WELL_WIDTH) << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [31:0] RST_COUPLING_STRENGTH =
		32'(((64'(MILLI_COUPLING_STRENGTH) << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [30:0] RST_COUPLING_WIDTH =
		31'(((64'(MILLI_COUPLING_WIDTH) << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [31:0] RST_ASYMPTOTE_OFFSET =
		32'(((64'(MILLI_ASYMPTOTE_OFFSET) << FRAC_BITS) + 64'd500) / 64'd1000);

	logic signed [31:0] well_depth_q;
	logic [30:0]        well_width_q;
	logic signed [31:0] coupling_strength_q;
	logic [30:0]        coupling_width_q;
	logic signed [31:0] asymptote_offset_q;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	logic [31:0]    ax_s1, ax_s2, ax_s3;
	logic           sx_s1, sx_s2, sx_s3;
	logic [63:0]    x2p_s2;
	logic [X2W-1:0] x2_s3;

	chan_res_t dres;
	chan_res_t cres;

	sat_t sat_de, sat_ce, sat_ds, sat_cs, sat_dc, sat_cc;

	logic signed [31:0] de_s20, ce_s20, ds_s20, cs_s20, dc_s20, cc_s20;
	logic               ov_s20;

	logic in_acc;
	logic out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			well_depth_q        <= RST_WELL_DEPTH;
			well_width_q        <= RST_WELL_WIDTH;
			coupling_strength_q <= RST_COUPLING_STRENGTH;
			coupling_width_q    <= RST_COUPLING_WIDTH;
			asymptote_offset_q  <= RST_ASYMPTOTE_OFFSET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WELL_DEPTH:        well_depth_q        <= cfg_data;
				REG_WELL_WIDTH:        well_width_q        <= cfg_data[30:0];
				REG_COUPLING_STRENGTH: coupling_strength_q <= cfg_data;
				REG_COUPLING_WIDTH:    coupling_width_q    <= cfg_data[30:0];
				REG_ASYMPTOTE_OFFSET:  asymptote_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when it is empty or the stage after it moves
	assign en[NS+1] = result.ready;
	for (genvar gk = 1; gk <= NS; gk++) begin : g_en
		assign en[gk] = ~vld_q[gk] | en[gk+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= coord.valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign coord.ready = en[1];
	assign in_acc      = coord.valid & coord.ready;
	assign out_acc     = result.valid & result.ready;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ax_s1 <= coord.coordinate[31] ? 32'(-coord.coordinate) : 32'(coord.coordinate);
			sx_s1 <= coord.coordinate[31];
		end
		if (en[2]) begin
			x2p_s2 <= 64'(ax_s1) * 64'(ax_s1);
			ax_s2  <= ax_s1;
			sx_s2  <= sx_s1;
		end
		if (en[3]) begin
			x2_s3 <= X2W'((x2p_s2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			ax_s3 <= ax_s2;
			sx_s3 <= sx_s2;
		end
	end

	dach_chan #(
		.FRAC_BITS       (FRAC_BITS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_diag (
		.clk    (clk),
		.en     (en[NS-1:4]),
		.width  (well_width_q),
		.amp    (well_depth_q),
		.x2_mag (x2_s3),
		.x_mag  (ax_s3),
		.x_neg  (sx_s3),
		.res    (dres)
	);

	dach_chan #(
		.FRAC_BITS       (FRAC_BITS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_coup (
		.clk    (clk),
		.en     (en[NS-1:4]),
		.width  (coupling_width_q),
		.amp    (coupling_strength_q),
		.x2_mag (x2_s3),
		.x_mag  (ax_s3),
		.x_neg  (sx_s3),
		.res    (cres)
	);

	// coupling slope and curvature carry the opposite sign of the lane's terms
	always_comb begin
		sat_de = sat32(64'(asymptote_offset_q) - 64'(dres.energy));
		sat_ce = sat32(64'(cres.energy));
		sat_ds = sat32(dres.slope);
		sat_cs = sat32(-cres.slope);
		sat_dc = sat32(dres.curv);
		sat_cc = sat32(-cres.curv);
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			de_s20 <= sat_de.value;
			ce_s20 <= sat_ce.value;
			ds_s20 <= sat_ds.value;
			cs_s20 <= sat_cs.value;
			dc_s20 <= sat_dc.value;
			cc_s20 <= sat_cc.value;
			ov_s20 <= dres.ovf | cres.ovf | sat_de.ovf | sat_ce.ovf | sat_ds.ovf
				| sat_cs.ovf | sat_dc.ovf | sat_cc.ovf;
		end
	end

	assign result.valid              = vld_q[NS];
	assign result.diag_energy        = de_s20;
	assign result.coupling_energy    = ce_s20;
	assign result.diag_slope         = ds_s20;
	assign result.coupling_slope     = cs_s20;
	assign result.diag_curvature     = dc_s20;
	assign result.coupling_curvature = cc_s20;
	assign result.overflow           = ov_s20;

	a_ready_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> coord.ready)
		else $error("input stalled although a pipeline stage is empty");

	a_drop_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(vld_q[NS]) |-> $past(result.ready))
		else $error("result dropped without being taken");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n |=> $countones(vld_q) ==
			$past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)))
		else $error("pipeline occupancy does not match accepted and delivered transactions");

endmodule
`default_nettype wire
